### hdl/mep_pkg.sv
// Package holding shared types and constants of the Mandelbrot escape pixel unit.
package mep_pkg;

    localparam int SIZE_BITS = 13;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_X_MIN = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_MIN = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_MAX = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_MAX = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ITER = 3'd6;

    typedef enum logic [1:0] {
        MAP_IDLE,
        MAP_DIVIDE,
        MAP_SCALE,
        MAP_DONE
    } map_state_t;

    typedef enum logic [2:0] {
        ESC_IDLE,
        ESC_SQUARE,
        ESC_TEST,
        ESC_UPDATE,
        ESC_OUTPUT
    } esc_state_t;

endpackage

### hdl/mandelbrot_escape_pixel_unit.sv
// Top level of the Mandelbrot escape pixel unit with configuration registers.
//
// Channel   Direction  Handshake            Beat
// pixel     in         push / full          pixel_column, pixel_row
// result    out        empty / pop          iteration_count, reached_cap
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The mapper runs a bit-serial division for each pixel, then a scaling step. Each
// escape iteration passes through the square, test and update states, with one
// squaring stage. The mapped point waits in the mapper while the escape loop is
// busy; one finished result waits in an output register. Reset restores window
// defaults.
module mandelbrot_escape_pixel_unit #(
    parameter int INDEX_BITS = 12,
    parameter int ITER_BITS = 16,
    parameter int COORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [INDEX_BITS-1:0]                 pixel_column,
    input  logic [INDEX_BITS-1:0]                 pixel_row,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [ITER_BITS-1:0]                  iteration_count,
    output logic                                  reached_cap,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mep_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [mep_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int SB = mep_pkg::SIZE_BITS;

    logic signed [COORD_BITS-1:0] x_min_reg, y_min_reg, x_max_reg, y_max_reg;
    logic [SB-1:0] width_reg, height_reg;
    logic [ITER_BITS-1:0] cap_reg;
    logic map_busy, map_done, esc_idle, rv;
    logic signed [COORD_BITS-1:0] cx, cy;
    logic hand;

    assign cfg_ready = 1'b1;
    assign full = map_busy;
    assign hand = map_done && esc_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= COORD_BITS'(-64'sd2 <<< (COORD_BITS - 4));
            y_min_reg <= COORD_BITS'(-64'sd1 <<< (COORD_BITS - 4));
            x_max_reg <= COORD_BITS'(64'sd1 <<< (COORD_BITS - 4));
            y_max_reg <= COORD_BITS'(64'sd1 <<< (COORD_BITS - 4));
            width_reg <= SB'(640);
            height_reg <= SB'(480);
            cap_reg <= ITER_BITS'(256);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mep_pkg::REG_X_MIN: x_min_reg <= cfg_data[COORD_BITS-1:0];
                mep_pkg::REG_Y_MIN: y_min_reg <= cfg_data[COORD_BITS-1:0];
                mep_pkg::REG_X_MAX: x_max_reg <= cfg_data[COORD_BITS-1:0];
                mep_pkg::REG_Y_MAX: y_max_reg <= cfg_data[COORD_BITS-1:0];
                mep_pkg::REG_WIDTH: width_reg <= cfg_data[SB-1:0];
                mep_pkg::REG_HEIGHT: height_reg <= cfg_data[SB-1:0];
                mep_pkg::REG_MAX_ITER: cap_reg <= cfg_data[ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

    mep_mapper #(
        .INDEX_BITS(INDEX_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_mapper (
        .clk(clk),
        .rst_n(rst_n),
        .start(push && !map_busy),
        .column(pixel_column),
        .row(pixel_row),
        .x_min(x_min_reg),
        .y_min(y_min_reg),
        .x_max(x_max_reg),
        .y_max(y_max_reg),
        .frame_width(width_reg),
        .frame_height(height_reg),
        .busy(map_busy),
        .done(map_done),
        .cx(cx),
        .cy(cy),
        .take(hand)
    );

    mep_escape #(
        .ITER_BITS(ITER_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_escape (
        .clk(clk),
        .rst_n(rst_n),
        .start(hand),
        .cx(cx),
        .cy(cy),
        .max_iterations(cap_reg),
        .idle(esc_idle),
        .result_valid(rv),
        .iteration_count(iteration_count),
        .reached_cap(reached_cap),
        .result_take(pop)
    );

    assign empty = !rv;

endmodule

### hdl/mep_mapper.sv
// Front part: maps a pixel position onto the complex plane by long division and scaling.
module mep_mapper #(
    parameter int INDEX_BITS = 12,
    parameter int COORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [INDEX_BITS-1:0]        column,
    input  logic [INDEX_BITS-1:0]        row,
    input  logic signed [COORD_BITS-1:0] x_min,
    input  logic signed [COORD_BITS-1:0] y_min,
    input  logic signed [COORD_BITS-1:0] x_max,
    input  logic signed [COORD_BITS-1:0] y_max,
    input  logic [mep_pkg::SIZE_BITS-1:0] frame_width,
    input  logic [mep_pkg::SIZE_BITS-1:0] frame_height,
    output logic                         busy,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] cx,
    output logic signed [COORD_BITS-1:0] cy,
    input  logic                         take
);

    localparam int SPAN_BITS = COORD_BITS + 1;
    localparam int SB = mep_pkg::SIZE_BITS;
    localparam int CNT_BITS = $clog2(SPAN_BITS + 1);

    mep_pkg::map_state_t state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SPAN_BITS-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [SB:0] rx_reg, rx_next, ry_reg, ry_next;
    logic negx_reg, negx_next, negy_reg, negy_next;
    logic [SB-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [INDEX_BITS-1:0] col_reg, col_next, row_reg, row_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;

    logic signed [SPAN_BITS-1:0] span_x, span_y;
    logic [SB:0] trx, try_;
    logic [SPAN_BITS-1:0] stx, sty;
    logic [COORD_BITS-1:0] px, py;

    assign span_x = SPAN_BITS'(x_max) - SPAN_BITS'(x_min);
    assign span_y = SPAN_BITS'(y_max) - SPAN_BITS'(y_min);
    assign trx = {rx_reg[SB-1:0], qx_reg[SPAN_BITS-1]};
    assign try_ = {ry_reg[SB-1:0], qy_reg[SPAN_BITS-1]};
    assign stx = negx_reg ? (~qx_reg + 1'b1) : qx_reg;
    assign sty = negy_reg ? (~qy_reg + 1'b1) : qy_reg;
    assign px = COORD_BITS'(stx[COORD_BITS-1:0] * COORD_BITS'(col_reg));
    assign py = COORD_BITS'(sty[COORD_BITS-1:0] * COORD_BITS'(row_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mep_pkg::MAP_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        negx_reg <= negx_next;
        negy_reg <= negy_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        col_reg <= col_next;
        row_reg <= row_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        negx_next = negx_reg;
        negy_next = negy_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        col_next = col_reg;
        row_next = row_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        case (state_reg)
            mep_pkg::MAP_IDLE:
            begin
                if (start)
                begin
                    negx_next = span_x[SPAN_BITS-1];
                    negy_next = span_y[SPAN_BITS-1];
                    qx_next = span_x[SPAN_BITS-1] ? (~span_x + 1'b1) : span_x;
                    qy_next = span_y[SPAN_BITS-1] ? (~span_y + 1'b1) : span_y;
                    rx_next = '0;
                    ry_next = '0;
                    dx_next = (frame_width == '0) ? SB'(1) : frame_width;
                    dy_next = (frame_height == '0) ? SB'(1) : frame_height;
                    col_next = column;
                    row_next = row;
                    cnt_next = '0;
                    state_next = mep_pkg::MAP_DIVIDE;
                end
            end
            mep_pkg::MAP_DIVIDE:
            begin
                if (trx >= {1'b0, dx_reg})
                begin
                    rx_next = trx - {1'b0, dx_reg};
                    qx_next = {qx_reg[SPAN_BITS-2:0], 1'b1};
                end
                else
                begin
                    rx_next = trx;
                    qx_next = {qx_reg[SPAN_BITS-2:0], 1'b0};
                end
                if (try_ >= {1'b0, dy_reg})
                begin
                    ry_next = try_ - {1'b0, dy_reg};
                    qy_next = {qy_reg[SPAN_BITS-2:0], 1'b1};
                end
                else
                begin
                    ry_next = try_;
                    qy_next = {qy_reg[SPAN_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(SPAN_BITS - 1))
                begin
                    state_next = mep_pkg::MAP_SCALE;
                end
            end
            mep_pkg::MAP_SCALE:
            begin
                cx_next = $signed(px + x_min);
                cy_next = $signed(py + y_min);
                state_next = mep_pkg::MAP_DONE;
            end
            mep_pkg::MAP_DONE:
            begin
                if (take)
                begin
                    state_next = mep_pkg::MAP_IDLE;
                end
            end
            default:
            begin
                state_next = mep_pkg::MAP_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != mep_pkg::MAP_IDLE);
    assign done = (state_reg == mep_pkg::MAP_DONE);
    assign cx = cx_reg;
    assign cy = cy_reg;

endmodule

### hdl/mep_escape.sv
// Back part: runs the escape-time iteration for one point with output register.
module mep_escape #(
    parameter int ITER_BITS = 16,
    parameter int COORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic [ITER_BITS-1:0]         max_iterations,
    output logic                         idle,
    output logic                         result_valid,
    output logic [ITER_BITS-1:0]         iteration_count,
    output logic                         reached_cap,
    input  logic                         result_take
);

    localparam int FRAC = COORD_BITS - 4;
    localparam int PW = 2 * COORD_BITS;
    localparam int SW = COORD_BITS + 4;

    mep_pkg::esc_state_t state_reg, state_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [ITER_BITS-1:0] cnt_reg, cnt_next, cap_reg, cap_next;
    logic signed [PW-1:0] xx_reg, yy_reg, xy_reg;
    logic signed [PW-1:0] xx_p, yy_p, xy_p;
    logic [SW-1:0] xxs, yys, mag;
    logic [COORD_BITS-1:0] nx, ny;
    logic cap_flag_reg, cap_flag_next, rv_reg, rv_next;
    logic [ITER_BITS-1:0] out_cnt_reg, out_cnt_next;

    assign xx_p = PW'(x_reg) * PW'(x_reg);
    assign yy_p = PW'(y_reg) * PW'(y_reg);
    assign xy_p = PW'(x_reg) * PW'(y_reg);
    assign xxs = SW'(xx_reg >>> FRAC);
    assign yys = SW'(yy_reg >>> FRAC);
    assign mag = xxs + yys;
    assign nx = COORD_BITS'(xx_reg >>> FRAC) - COORD_BITS'(yy_reg >>> FRAC)
                + COORD_BITS'(cx_reg);
    assign ny = COORD_BITS'(xy_reg >>> (FRAC - 1)) + COORD_BITS'(cy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mep_pkg::ESC_IDLE;
            rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cnt_reg <= cnt_next;
        cap_reg <= cap_next;
        xx_reg <= xx_p;
        yy_reg <= yy_p;
        xy_reg <= xy_p;
        cap_flag_reg <= cap_flag_next;
        out_cnt_reg <= out_cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg;
        y_next = y_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cnt_next = cnt_reg;
        cap_next = cap_reg;
        rv_next = rv_reg;
        cap_flag_next = cap_flag_reg;
        out_cnt_next = out_cnt_reg;
        if (rv_reg && result_take)
        begin
            rv_next = 1'b0;
        end
        case (state_reg)
            mep_pkg::ESC_IDLE:
            begin
                if (start)
                begin
                    x_next = '0;
                    y_next = '0;
                    cx_next = cx;
                    cy_next = cy;
                    cnt_next = '0;
                    cap_next = max_iterations;
                    state_next = mep_pkg::ESC_SQUARE;
                end
            end
            mep_pkg::ESC_SQUARE:
            begin
                state_next = mep_pkg::ESC_TEST;
            end
            mep_pkg::ESC_TEST:
            begin
                if (cnt_reg == cap_reg || mag >= SW'(4) << FRAC)
                begin
                    state_next = mep_pkg::ESC_OUTPUT;
                end
                else
                begin
                    state_next = mep_pkg::ESC_UPDATE;
                end
            end
            mep_pkg::ESC_UPDATE:
            begin
                x_next = $signed(nx);
                y_next = $signed(ny);
                cnt_next = cnt_reg + 1'b1;
                state_next = mep_pkg::ESC_SQUARE;
            end
            mep_pkg::ESC_OUTPUT:
            begin
                if (!rv_reg || result_take)
                begin
                    rv_next = 1'b1;
                    out_cnt_next = cnt_reg;
                    cap_flag_next = (cnt_reg == cap_reg);
                    state_next = mep_pkg::ESC_IDLE;
                end
            end
            default:
            begin
                state_next = mep_pkg::ESC_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == mep_pkg::ESC_IDLE);
    assign result_valid = rv_reg;
    assign iteration_count = out_cnt_reg;
    assign reached_cap = cap_flag_reg;

endmodule
